// ===== sv/fpcd_pkg.sv =====
// Package for the fixed prefix-code decoder: widths, code tree tables,
// and the link type passed between neighboring bit cells.
// No dependencies.
`default_nettype none
package fpcd_pkg;

    localparam int CODE_W       = 8;   // code_bits width
    localparam int COUNT_W      = 4;   // bit_count width
    localparam int SYM_W        = 8;   // symbol width
    localparam int POS_W        = 4;   // tree node index width
    localparam int SLOT_W       = 2;   // result slot index / count width
    localparam int MAX_RESULTS  = 3;   // symbols one item can complete
    localparam int BITS_PER_ITEM_DEF = 8;
    localparam int QUEUE_DEPTH  = 4;   // output queue entries
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [POS_W-1:0] ROOT_NODE = 4'd0;

    // Carried from one bit cell to the next.
    typedef struct packed {
        logic [POS_W-1:0]  pos;   // tree node reached so far
        logic [SLOT_W-1:0] cnt;   // symbols completed so far, saturates at 3
    } t_cell_link;

    // One output queue entry.
    typedef struct packed {
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_qentry;

    // Child node index when the child is an internal node.
    function automatic logic [POS_W-1:0] fpcd_next(input logic [POS_W-1:0] pos,
                                                   input logic b);
        logic [POS_W-1:0] nxt;
        nxt = ROOT_NODE;
        unique case (pos)
            4'd0:    nxt = b ? 4'd2  : 4'd1;
            4'd1:    nxt = b ? 4'd4  : 4'd3;
            4'd2:    nxt = b ? 4'd10 : 4'd9;
            4'd4:    nxt = b ? 4'd5  : 4'd0;
            4'd5:    nxt = b ? 4'd6  : 4'd0;
            4'd6:    nxt = b ? 4'd7  : 4'd0;
            4'd7:    nxt = b ? 4'd0  : 4'd8;
            4'd10:   nxt = b ? 4'd12 : 4'd11;
            4'd12:   nxt = b ? 4'd0  : 4'd13;
            4'd14,
            4'd15:   nxt = b ? 4'd2  : 4'd1;   // unreachable nodes act as root
            default: nxt = ROOT_NODE;
        endcase
        return nxt;
    endfunction

    // ASCII code when the child is a leaf, zero when it is internal.
    function automatic logic [SYM_W-1:0] fpcd_leaf(input logic [POS_W-1:0] pos,
                                                   input logic b);
        logic [SYM_W-1:0] sym;
        sym = '0;
        unique case (pos)
            4'd3:    sym = b ? "1" : "2";
            4'd4:    sym = b ? 8'd0 : "+";
            4'd5:    sym = b ? 8'd0 : "6";
            4'd6:    sym = b ? 8'd0 : "9";
            4'd7:    sym = b ? "0" : 8'd0;
            4'd8:    sym = b ? ")" : "(";
            4'd9:    sym = b ? "a" : "*";
            4'd11:   sym = b ? "4" : "5";
            4'd12:   sym = b ? "3" : 8'd0;
            4'd13:   sym = b ? "8" : "7";
            default: sym = '0;
        endcase
        return sym;
    endfunction

endpackage
`default_nettype wire

// ===== sv/fixed_prefix_code_decoder.sv =====
// Top level of the fixed prefix-code decoder: bit cell chain, tree position
// register and output queue. Depends on fpcd_pkg, fpcd_cell, fpcd_outq.
//
// Decodes a bit stream against a fixed 15-symbol prefix code (digits, '+',
// '*', 'a', '(' and ')', codes of 3 to 7 bits). Each input beat carries up
// to eight code bits, most significant first, a bit count in tdata and a
// message-end flag in tlast; message end drops any partial code after the
// beat's bits are decoded. Each completed symbol leaves as one output beat
// with its ASCII code, and tlast marks the final symbol a beat produced; a
// beat that completes no symbol produces no output. Timing: a row of
// BITS_PER_ITEM identical bit cells walks the tree for a whole beat
// combinationally, so input beats are taken back to back as long as each
// yields at most one symbol and the output is not stalled. Results go
// through a four-entry queue that drains one symbol per cycle while the
// output is ready; an input beat is taken whenever the queue holds at most
// one entry, so a beat yielding k symbols leaves as k output beats.
`default_nettype none
module fixed_prefix_code_decoder #(
    parameter int BITS_PER_ITEM = fpcd_pkg::BITS_PER_ITEM_DEF   // 1..8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // [7:0] code_bits, [11:8] bit_count, [15:12] zero
    input  logic        i_s_tlast,    // message_end
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // [7:0] symbol
    output logic        o_m_tlast     // last_of_run
);
    import fpcd_pkg::*;

    logic [CODE_W-1:0]  code_bits;
    logic [COUNT_W-1:0] bit_count;
    logic               accept;

    logic [POS_W-1:0]   r_pos, n_pos;

    t_cell_link         link [BITS_PER_ITEM+1];
    logic               emit [BITS_PER_ITEM];
    logic [SLOT_W-1:0]  slot [BITS_PER_ITEM];
    logic [SYM_W-1:0]   csym [BITS_PER_ITEM];

    t_qentry            q_in [MAX_RESULTS];
    t_qentry            q_out;
    logic               q_room;
    logic [SLOT_W-1:0]  n_res;

    assign code_bits = i_s_tdata[CODE_W-1:0];
    assign bit_count = i_s_tdata[CODE_W+COUNT_W-1:CODE_W];
    assign accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready = q_room;

    // Chain head: current tree position, no symbols yet.
    assign link[0].pos = r_pos;
    assign link[0].cnt = '0;

    // One cell per bit; cell i looks at bit 7-i and is live while i < bit_count.
    // Counts above BITS_PER_ITEM fall off the end of the chain.
    for (genvar g = 0; g < BITS_PER_ITEM; g++) begin : g_cell
        fpcd_cell u_cell (
            .i_link (link[g]),
            .i_bit  (code_bits[CODE_W-1-g]),
            .i_act  (COUNT_W'(g) < bit_count),
            .o_link (link[g+1]),
            .o_emit (emit[g]),
            .o_slot (slot[g]),
            .o_sym  (csym[g])
        );
    end

    assign n_res = link[BITS_PER_ITEM].cnt;

    // Gather each claimed slot's symbol; a slot is claimed by at most one cell.
    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            q_in[k].sym  = '0;
            q_in[k].last = (SLOT_W'(k) + 1'b1 == n_res);
            for (int c = 0; c < BITS_PER_ITEM; c++) begin
                if (emit[c] && (slot[c] == SLOT_W'(k))) begin
                    q_in[k].sym = q_in[k].sym | csym[c];
                end
            end
        end
    end

    // Advance the tree position on each accepted beat; message end drops it.
    assign n_pos = i_s_tlast ? ROOT_NODE : link[BITS_PER_ITEM].pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ROOT_NODE;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    fpcd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_push_n (n_res),
        .i_data   (q_in),
        .o_room   (q_room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (q_out)
    );

    assign o_m_tdata = q_out.sym;
    assign o_m_tlast = q_out.last;

endmodule
`default_nettype wire

// ===== sv/fpcd_cell.sv =====
// One bit cell of the decoder chain: steps the tree position by one bit
// and reports a completed symbol. Depends on fpcd_pkg.
`default_nettype none
module fpcd_cell (
    input  fpcd_pkg::t_cell_link        i_link,
    input  logic                        i_bit,
    input  logic                        i_act,
    output fpcd_pkg::t_cell_link        o_link,
    output logic                        o_emit,
    output logic [fpcd_pkg::SLOT_W-1:0] o_slot,
    output logic [fpcd_pkg::SYM_W-1:0]  o_sym
);
    import fpcd_pkg::*;

    logic [SYM_W-1:0] leaf_sym;
    logic             is_leaf;
    logic             room;

    assign leaf_sym = fpcd_leaf(i_link.pos, i_bit);
    assign is_leaf  = (leaf_sym != '0);
    assign room     = (i_link.cnt < SLOT_W'(MAX_RESULTS));

    assign o_sym  = leaf_sym;
    assign o_slot = i_link.cnt;
    assign o_emit = i_act && is_leaf && room;

    always_comb begin
        o_link = i_link;
        if (i_act) begin
            if (is_leaf) begin
                // return to root, claim the next result slot if one is left
                o_link.pos = ROOT_NODE;
                if (room) begin
                    o_link.cnt = i_link.cnt + 1'b1;
                end
            end else begin
                o_link.pos = fpcd_next(i_link.pos, i_bit);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/fpcd_outq.sv =====
// Output queue of decoded symbols: takes up to three entries per cycle,
// hands out one per beat. Depends on fpcd_pkg.
`default_nettype none
module fpcd_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [fpcd_pkg::SLOT_W-1:0] i_push_n,
    input  fpcd_pkg::t_qentry           i_data [fpcd_pkg::MAX_RESULTS],
    output logic                        o_room,
    output logic                        o_valid,
    input  logic                        i_ready,
    output fpcd_pkg::t_qentry           o_data
);
    import fpcd_pkg::*;

    t_qentry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic [QCNT_W-1:0]   push_n;
    logic                pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign push_n  = i_push ? QCNT_W'(i_push_n) : '0;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    // room for a full item of three results
    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    assign n_wr  = r_wr + push_n[QPTR_W-1:0];
    assign n_rd  = r_rd + QPTR_W'(pop);
    assign n_cnt = r_cnt + push_n - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (QCNT_W'(j) < push_n) begin
                r_mem[r_wr + QPTR_W'(j)] <= i_data[j];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/fpcd_checker.sv =====
// Port-level checker for the fixed prefix-code decoder, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module fpcd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  o_m_tdata,
    input  logic        o_m_tlast
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // Reset empties the result queue.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // With no pending result the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // Only code alphabet symbols come out.
    a_sym_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39)
                        || o_m_tdata == 8'h2B || o_m_tdata == 8'h2A
                        || o_m_tdata == 8'h61 || o_m_tdata == 8'h28
                        || o_m_tdata == 8'h29))
        else $error("symbol outside the code alphabet");

endmodule

bind fixed_prefix_code_decoder fpcd_checker u_fpcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

// ===== bench/fixed_prefix_code_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_prefix_code_decoder: drives code-bit beats,
// predicts the decoded symbols with its own tree walk and checks every beat.
// Depends on fpcd_pkg and fixed_prefix_code_decoder.
module fixed_prefix_code_decoder_tb;

    import fpcd_pkg::*;

    localparam int BITS_PER_ITEM = 8;
    localparam int RANDOM_BEATS  = 430;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLDOFF_LEN   = 400;

    // One input beat as the decoder sees it.
    typedef struct {
        logic [CODE_W-1:0]  code_bits;
        logic [COUNT_W-1:0] bit_count;
        logic               msg_end;
    } t_code_beat;

    // One decoded symbol as it should leave the block.
    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_symbol_beat;

    // Result of one step down the code tree.
    typedef struct {
        logic [POS_W-1:0] node;
        logic [SYM_W-1:0] sym;    // zero while the code is unfinished
    } t_tree_move;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;    // [7:0] code_bits, [11:8] bit_count, [15:12] zero
    logic        i_s_tlast  = 1'b0;  // message_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;          // [7:0] symbol
    logic        o_m_tlast;          // last_of_run

    t_code_beat   pending_beats[$];     // beats still to be offered
    t_symbol_beat expected_symbols[$];  // decoded symbols not yet seen
    bit           msg_bits[$];          // code bits of the message being built

    logic [POS_W-1:0] decode_node = ROOT_NODE;  // predicted tree position
    t_code_beat   offered;
    t_symbol_beat want;
    int           beats_taken     = 0;
    int           total_beats     = 0;
    int           mismatch_count  = 0;
    int           cycle_count     = 0;
    int           gap_left        = 0;
    int           burst_left      = 1;
    int           holdoff_left    = 0;
    int           holdoff_trigger = 150;
    int           stall_mode      = 0;
    int           stall_phase     = 0;

    fixed_prefix_code_decoder #(
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One step down the tree. Nodes 14 and 15 are never reached; treat
    // them as the root.
    function automatic t_tree_move tree_step(input logic [POS_W-1:0] node,
                                             input logic b);
        t_tree_move mv;
        mv.node = ROOT_NODE;
        mv.sym  = '0;
        case ({node, b})
            {4'd0, 1'b0}, {4'd14, 1'b0}, {4'd15, 1'b0}: mv.node = 4'd1;
            {4'd0, 1'b1}, {4'd14, 1'b1}, {4'd15, 1'b1}: mv.node = 4'd2;
            {4'd1, 1'b0}:  mv.node = 4'd3;
            {4'd1, 1'b1}:  mv.node = 4'd4;
            {4'd2, 1'b0}:  mv.node = 4'd9;
            {4'd2, 1'b1}:  mv.node = 4'd10;
            {4'd3, 1'b0}:  mv.sym  = "2";
            {4'd3, 1'b1}:  mv.sym  = "1";
            {4'd4, 1'b0}:  mv.sym  = "+";
            {4'd4, 1'b1}:  mv.node = 4'd5;
            {4'd5, 1'b0}:  mv.sym  = "6";
            {4'd5, 1'b1}:  mv.node = 4'd6;
            {4'd6, 1'b0}:  mv.sym  = "9";
            {4'd6, 1'b1}:  mv.node = 4'd7;
            {4'd7, 1'b0}:  mv.node = 4'd8;
            {4'd7, 1'b1}:  mv.sym  = "0";
            {4'd8, 1'b0}:  mv.sym  = "(";
            {4'd8, 1'b1}:  mv.sym  = ")";
            {4'd9, 1'b0}:  mv.sym  = "*";
            {4'd9, 1'b1}:  mv.sym  = "a";
            {4'd10, 1'b0}: mv.node = 4'd11;
            {4'd10, 1'b1}: mv.node = 4'd12;
            {4'd11, 1'b0}: mv.sym  = "5";
            {4'd11, 1'b1}: mv.sym  = "4";
            {4'd12, 1'b0}: mv.node = 4'd13;
            {4'd12, 1'b1}: mv.sym  = "3";
            {4'd13, 1'b0}: mv.sym  = "7";
            {4'd13, 1'b1}: mv.sym  = "8";
            default:       mv.node = ROOT_NODE;
        endcase
        return mv;
    endfunction

    // Walk the tree over one accepted beat and queue the symbols it completes.
    task automatic predict_symbols(input t_code_beat cb);
        int           nbits;
        int           produced;
        t_tree_move   mv;
        t_symbol_beat sb;
        nbits    = int'(cb.bit_count);
        produced = 0;
        // clamp the count to the bits one beat can carry
        if (nbits > BITS_PER_ITEM) nbits = BITS_PER_ITEM;
        if (nbits > CODE_W) nbits = CODE_W;
        for (int i = 0; i < nbits; i++) begin
            mv = tree_step(decode_node, cb.code_bits[CODE_W-1-i]);
            if (mv.sym != '0) begin
                if (produced < MAX_RESULTS) begin
                    sb.sym  = mv.sym;
                    sb.last = 1'b0;
                    expected_symbols.push_back(sb);
                    produced++;
                end
                decode_node = ROOT_NODE;
            end else begin
                decode_node = mv.node;
            end
        end
        // mark the final symbol of this beat
        if (produced > 0)
            expected_symbols[expected_symbols.size()-1].last = 1'b1;
        // message end drops any partial code
        if (cb.msg_end)
            decode_node = ROOT_NODE;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic push_beat(input logic [CODE_W-1:0] bits, input int count,
                             input logic msg_end);
        t_code_beat cb;
        cb.code_bits = bits;
        cb.bit_count = count[COUNT_W-1:0];
        cb.msg_end   = msg_end;
        pending_beats.push_back(cb);
    endtask

    // Append the code of one symbol, first bit first. Index order follows
    // the code table: 2 1 + 6 9 0 ( ) * a 5 4 3 7 8.
    task automatic append_symbol(input int idx);
        logic [6:0] code;
        int         len;
        case (idx)
            0:  begin code = 7'b000;     len = 3; end
            1:  begin code = 7'b001;     len = 3; end
            2:  begin code = 7'b010;     len = 3; end
            3:  begin code = 7'b0110;    len = 4; end
            4:  begin code = 7'b01110;   len = 5; end
            5:  begin code = 7'b011111;  len = 6; end
            6:  begin code = 7'b0111100; len = 7; end
            7:  begin code = 7'b0111101; len = 7; end
            8:  begin code = 7'b100;     len = 3; end
            9:  begin code = 7'b101;     len = 3; end
            10: begin code = 7'b1100;    len = 4; end
            11: begin code = 7'b1101;    len = 4; end
            12: begin code = 7'b1111;    len = 4; end
            13: begin code = 7'b11100;   len = 5; end
            default: begin code = 7'b11101; len = 5; end
        endcase
        for (int i = len - 1; i >= 0; i--)
            msg_bits.push_back(code[i]);
    endtask

    // Cut the message bits into beats of random size. Bits below the count
    // carry junk; full beats sometimes carry an oversized count.
    task automatic split_bits(input logic end_flag);
        logic [CODE_W-1:0] bits;
        int                take;
        int                count;
        while (msg_bits.size() > 0) begin
            if ($urandom_range(0, 15) == 0)
                push_beat(CODE_W'($urandom_range(0, 255)), 0, 1'b0);
            take = $urandom_range(1, 8);
            if (take > msg_bits.size()) take = msg_bits.size();
            bits = CODE_W'($urandom_range(0, 255));
            for (int i = 0; i < take; i++)
                bits[CODE_W-1-i] = msg_bits.pop_front();
            count = take;
            if (take == 8 && $urandom_range(0, 3) == 0)
                count = $urandom_range(9, 15);
            push_beat(bits, count, (msg_bits.size() == 0) ? end_flag : 1'b0);
        end
    endtask

    // A message of random symbols; a broken one loses its tail or has a
    // bit flipped, and always closes with message end.
    task automatic build_message(input int nsym, input bit broken, input logic end_flag);
        int drop;
        msg_bits.delete();
        for (int i = 0; i < nsym; i++)
            append_symbol($urandom_range(0, 14));
        if (broken) begin
            if ($urandom_range(0, 1) == 1 && msg_bits.size() > 4) begin
                drop = $urandom_range(1, 3);
                repeat (drop) void'(msg_bits.pop_back());
            end else begin
                drop = $urandom_range(0, msg_bits.size() - 1);
                msg_bits[drop] = ~msg_bits[drop];
            end
        end
        split_bits(broken ? 1'b1 : end_flag);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued beats in bursts, predict on every accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_symbols(offered);
                beats_taken <= beats_taken + 1;
            end
            // advance only when nothing is held or the held beat just went
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    offered = pending_beats.pop_front();
                    i_s_tdata  <= {4'b0000, offered.bit_count, offered.code_bits};
                    i_s_tlast  <= offered.msg_end;
                    i_s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a changing pattern, with long hold-offs so the
    // output queue fills and the input side has to stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 50 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                i_m_tready   <= 1'b0;
            end else if (beats_taken >= holdoff_trigger) begin
                // hold off while the sender keeps offering
                holdoff_left    <= HOLDOFF_LEN;
                holdoff_trigger <= holdoff_trigger + 180;
                i_m_tready      <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_tready <= (stall_phase % 4 == 0);
                    default: i_m_tready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest expected symbol
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_symbols.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol 0x%02h", o_m_tdata));
            end else begin
                want = expected_symbols.pop_front();
                if (o_m_tdata !== want.sym)
                    report_mismatch($sformatf("symbol 0x%02h, want 0x%02h",
                                              o_m_tdata, want.sym));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b on 0x%02h",
                                              o_m_tlast, want.last, want.sym));
            end
        end
    end

    // Watchdog: end the run if the decoder hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the queue, release reset, wait for the drain
    // ------------------------------------------------------------------
    initial begin : sequencer
        int n_directed;
        int pick;

        // two full-beat symbols, leaving a partial code behind
        push_beat(8'h00, 8, 1'b0);
        // one bit finishes the carried code
        push_beat(8'h80, 1, 1'b0);
        push_beat(8'hFF, 8, 1'b0);
        // carry two bits, then three symbols in one beat
        push_beat(8'h00, 2, 1'b0);
        push_beat(8'b0000_0010, 8, 1'b0);
        // zero count with message end: only the partial code is dropped
        push_beat(8'h7F, 0, 1'b1);
        // message end drops a partial code; next beat starts at the root
        push_beat(8'h60, 3, 1'b1);
        push_beat(8'h20, 3, 1'b0);
        // counts above eight clamp to eight
        push_beat(8'hFF, 15, 1'b0);
        // symbols finished in a message-end beat still come out
        push_beat(8'h00, 9, 1'b1);
        push_beat(8'hAA, 8, 1'b0);
        push_beat(8'h55, 8, 1'b0);
        push_beat(8'h00, 0, 1'b0);
        push_beat(8'hF0, 12, 1'b0);
        push_beat(8'h0F, 8, 1'b1);
        // every symbol of the code once
        msg_bits.delete();
        for (int s = 0; s < 15; s++)
            append_symbol(s);
        split_bits(1'b1);
        n_directed = pending_beats.size();

        // mostly well-formed messages, some broken ones and raw noise
        while (pending_beats.size() < n_directed + RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                build_message($urandom_range(1, 10), 1'b0, $urandom_range(0, 3) != 0);
            else if (pick == 7)
                build_message($urandom_range(1, 8), 1'b1, 1'b1);
            else
                repeat ($urandom_range(1, 4))
                    push_beat(CODE_W'($urandom_range(0, 255)), $urandom_range(0, 15),
                              $urandom_range(0, 3) == 0);
        end
        total_beats = pending_beats.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats) @(posedge i_clk);
        while (expected_symbols.size() != 0) @(posedge i_clk);
        // hold a little longer to catch stray output beats
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_symbols.size() != 0)
            report_mismatch("expected symbols left at the end");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
